// ===== hw/rtl/rational_mixed_arith_unit_macros.svh =====
// assertion helpers for the rtl files, used by rma_control
`ifndef RATIONAL_MIXED_ARITH_UNIT_MACROS_SVH
`define RATIONAL_MIXED_ARITH_UNIT_MACROS_SVH

// implication checked every clock, idle during reset
`define RMA_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked every clock
`define RMA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rma_pkg.sv =====
`default_nettype none
package rma_pkg;
  localparam int unsigned WordBitsDefault = 32;
  localparam int unsigned IoBits = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // datapath sequencing steps
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_FLAT_A   = 4'd2,
    OP_FLAT_B   = 4'd3,
    OP_CROSS1   = 4'd4,
    OP_CROSS2   = 4'd5,
    OP_DEN      = 4'd6,
    OP_COMB     = 4'd7,
    OP_DIV1     = 4'd8,
    OP_GCD      = 4'd9,
    OP_DIV2     = 4'd10,
    OP_DIV3     = 4'd11,
    OP_FINISH   = 4'd12,
    OP_GCD_INIT = 4'd13
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic dzero;
    logic gcd_done;
  } dp_status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rma_divider.sv =====
`default_nettype none
// restoring unsigned divider, one quotient bit per cycle
module rma_divider #(
  parameter int unsigned WORD_BITS = rma_pkg::WordBitsDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] dividend,
  input  wire logic [WORD_BITS-1:0] divisor,
  output logic                      busy,
  output logic [WORD_BITS-1:0]      quot,
  output logic [WORD_BITS-1:0]      rem
);
  import rma_pkg::*;
  localparam int unsigned CntBits = $clog2(WORD_BITS + 1);

  logic [CntBits-1:0]   cnt;
  logic [WORD_BITS-1:0] dvs;
  logic [WORD_BITS:0]   trial;

  // shift in next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quot[WORD_BITS-1]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntBits'(WORD_BITS);
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial[WORD_BITS]) begin
        rem <= {rem[WORD_BITS-2:0], quot[WORD_BITS-1]};
        quot <= {quot[WORD_BITS-2:0], 1'b0};
      end else begin
        rem <= trial[WORD_BITS-1:0];
        quot <= {quot[WORD_BITS-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rma_datapath.sv =====
`default_nettype none
module rma_datapath #(
  parameter int unsigned WORD_BITS = rma_pkg::WordBitsDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rma_pkg::dp_cmd_t      dcmd,
  output rma_pkg::dp_status_t        status,
  input  wire logic [1:0]            cmd,
  input  wire logic [31:0]           a_whole,
  input  wire logic [31:0]           a_numer,
  input  wire logic [31:0]           a_denom,
  input  wire logic [31:0]           b_whole,
  input  wire logic [31:0]           b_numer,
  input  wire logic [31:0]           b_denom,
  output logic [31:0]                res_whole,
  output logic [31:0]                res_numer,
  output logic [31:0]                res_denom,
  output logic                       res_dz
);
  import rma_pkg::*;
  localparam int unsigned W = WORD_BITS;

  logic [1:0]   op_code;
  logic [W-1:0] aw, an, ad, bw, bn, bd, fa, fb, p1, p2, n, d;
  logic [W-1:0] nm, dm, gx, gy, qv, rm;
  logic [W-1:0] num_r, den_r;
  logic         nn, dn;
  logic [W-1:0] mul_x, mul_y, mul_p;
  logic         div_start, div_busy;
  logic [W-1:0] div_a, div_b, div_q, div_r;

  // wide-or-narrow sign extension of a 32-bit port
  function automatic logic [W-1:0] sx(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[W-1:0];
  endfunction

  function automatic logic [31:0] to_io(input logic [W-1:0] v);
    logic [95:0] e;
    e = {{96-W{v[W-1]}}, v};
    return e[31:0];
  endfunction

  // single shared multiplier, operands picked by step
  always_comb begin
    mul_x = fa;
    mul_y = bd;
    case (dcmd.op)
      OP_FLAT_A: begin mul_x = aw; mul_y = ad; end
      OP_FLAT_B: begin mul_x = bw; mul_y = bd; end
      OP_CROSS1: begin
        mul_x = fa;
        mul_y = (op_code == CMD_MUL) ? fb : bd;
      end
      OP_CROSS2: begin mul_x = fb; mul_y = ad; end
      OP_DEN:    begin mul_x = ad; mul_y = bd; end
      default:   begin mul_x = fa; mul_y = bd; end
    endcase
    mul_p = mul_x * mul_y;
  end

  // divider operands per step
  always_comb begin
    div_start = dcmd.start;
    div_a = nm;
    div_b = dm;
    case (dcmd.op)
      OP_GCD:  begin div_a = gx; div_b = gy; end
      OP_DIV2: begin div_a = rm; div_b = gx; end
      OP_DIV3: begin div_a = dm; div_b = gx; end
      default: begin div_a = nm; div_b = dm; end
    endcase
  end

  rma_divider #(.WORD_BITS(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quot(div_q), .rem(div_r)
  );

  assign status.busy = div_busy | div_start;
  assign status.dzero = (d == '0);
  assign status.gcd_done = (gy == '0);

  always_ff @(posedge clk) begin
    case (dcmd.op)
      OP_LOAD: begin
        op_code <= cmd;
        aw <= sx(a_whole); an <= sx(a_numer); ad <= sx(a_denom);
        bw <= sx(b_whole); bn <= sx(b_numer); bd <= sx(b_denom);
      end
      OP_FLAT_A: fa <= an + mul_p;
      OP_FLAT_B: fb <= bn + mul_p;
      OP_CROSS1: p1 <= mul_p;
      OP_CROSS2: p2 <= mul_p;
      OP_DEN: begin
        d <= (op_code == CMD_DIV) ? p2 : mul_p;
      end
      OP_COMB: begin
        case (op_code)
          CMD_ADD: n <= p1 + p2;
          CMD_SUB: n <= p1 - p2;
          default: n <= p1;
        endcase
        nn <= 1'b0;
      end
      // magnitudes latched in the cycle before the divider starts on them
      OP_DIV1: begin
        if (!dcmd.start) begin
          nn <= n[W-1];
          dn <= d[W-1];
          nm <= n[W-1] ? -n : n;
          dm <= d[W-1] ? -d : d;
        end
      end
      // keep whole part and remainder, seed euclid with (dm, rm)
      OP_GCD_INIT: begin
        qv <= div_q;
        rm <= div_r;
        gx <= dm;
        gy <= div_r;
      end
      // one euclid step once the remainder is ready
      OP_GCD: begin
        if (!dcmd.start && !div_busy) begin
          gx <= gy;
          gy <= div_r;
        end
      end
      OP_DIV2: if (!div_busy && !dcmd.start) num_r <= nn ? -div_q : div_q;
      OP_DIV3: if (!div_busy && !dcmd.start) den_r <= dn ? -div_q : div_q;
      OP_FINISH: begin
        res_dz <= (d == '0);
        if (d == '0) begin
          res_whole <= '0; res_numer <= '0; res_denom <= '0;
        end else begin
          res_whole <= to_io((nn != dn) ? -qv : qv);
          res_numer <= to_io(num_r);
          res_denom <= to_io(den_r);
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rma_control.sv =====
`default_nettype none
module rma_control (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rma_pkg::dp_cmd_t         dcmd,
  input  wire rma_pkg::dp_status_t status
);
  import rma_pkg::*;
  `include "rational_mixed_arith_unit_macros.svh"

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_FA    = 13'b0000000000010,
    S_FB    = 13'b0000000000100,
    S_C1    = 13'b0000000001000,
    S_C2    = 13'b0000000010000,
    S_DEN   = 13'b0000000100000,
    S_COMB  = 13'b0000001000000,
    S_DIV1  = 13'b0000010000000,
    S_GCDS  = 13'b0000100000000,
    S_GCD   = 13'b0001000000000,
    S_DIV2  = 13'b0010000000000,
    S_DIV3  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   started, started_next;
  logic   out_valid_next;
  logic   accept;

  // input taken whenever idle, a waiting result is not touched
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    started_next = 1'b0;
    dcmd.op = OP_NONE;
    dcmd.start = 1'b0;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        dcmd.op = OP_LOAD;
        if (accept) state_next = S_FA;
      end
      S_FA:   begin dcmd.op = OP_FLAT_A; state_next = S_FB; end
      S_FB:   begin dcmd.op = OP_FLAT_B; state_next = S_C1; end
      S_C1:   begin dcmd.op = OP_CROSS1; state_next = S_C2; end
      S_C2:   begin dcmd.op = OP_CROSS2; state_next = S_DEN; end
      S_DEN:  begin dcmd.op = OP_DEN; state_next = S_COMB; end
      S_COMB: begin
        dcmd.op = OP_COMB;
        state_next = status.dzero ? S_FIN : S_DIV1;
      end
      // latches magnitudes, then starts the whole-part division
      S_DIV1: begin
        dcmd.op = OP_DIV1;
        dcmd.start = started;
        started_next = !started;
        if (started) state_next = S_GCDS;
      end
      S_GCDS: begin
        if (!status.busy) begin
          dcmd.op = OP_GCD_INIT;
          state_next = S_GCD;
        end
      end
      // euclid loop: start a division, wait, then shift the pair; leave when gy is zero
      S_GCD: begin
        if (!started) begin
          if (status.gcd_done) begin
            state_next = S_DIV2;
          end else begin
            dcmd.op = OP_GCD;
            dcmd.start = 1'b1;
            started_next = 1'b1;
          end
        end else begin
          dcmd.op = OP_GCD;
          started_next = status.busy;
        end
      end
      S_DIV2: begin
        dcmd.op = OP_DIV2;
        dcmd.start = !started;
        started_next = 1'b1;
        if (started && !status.busy) begin
          started_next = 1'b0;
          state_next = S_DIV3;
        end
      end
      S_DIV3: begin
        dcmd.op = OP_DIV3;
        dcmd.start = !started;
        started_next = 1'b1;
        if (started && !status.busy) begin
          started_next = 1'b0;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!(out_valid && out_stall)) begin
          dcmd.op = OP_FINISH;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      started <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      started <= started_next;
      out_valid <= out_valid_next;
    end
  end

  `RMA_ASSERT_NEXT(a_acc_busy, clk, rst, accept, state == S_FA)
  `RMA_ASSERT_IMP(a_fin_hold, clk, rst, (state == S_FIN) && out_valid && out_stall,
    dcmd.op == OP_NONE)
  `RMA_ASSERT_NEXT(a_fin_valid, clk, rst, dcmd.op == OP_FINISH, out_valid)
endmodule
`default_nettype wire

// ===== hw/rtl/rational_mixed_arith_unit.sv =====
`default_nettype none
// rational arithmetic on mixed fractions with gcd reduction
// input channel: in_valid/in_stall with cmd and two operands (whole,
// numer, denom); a transfer happens when in_valid is high and in_stall low
// output channel: out_valid/out_stall with res_whole, res_numer,
// res_denom and div_zero; the result register holds while stalled
// one item at a time: in_stall is high from the transfer until the result
// is loaded into the output register
// a single restoring divider, one quotient bit a cycle, serves the
// whole-part division, each euclid step and both reducing divisions;
// a zero denominator skips the divider
// a new item may enter while the previous result still waits; the new
// result is loaded only once the old one has left
// synchronous reset returns to idle with no result pending
module rational_mixed_arith_unit #(
  parameter int unsigned WORD_BITS = rma_pkg::WordBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] a_whole,
  input  wire logic [31:0] a_numer,
  input  wire logic [31:0] a_denom,
  input  wire logic [31:0] b_whole,
  input  wire logic [31:0] b_numer,
  input  wire logic [31:0] b_denom,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      res_whole,
  output logic [31:0]      res_numer,
  output logic [31:0]      res_denom,
  output logic             div_zero
);
  import rma_pkg::*;

  dp_cmd_t    dcmd;
  dp_status_t status;

  rma_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .dcmd(dcmd), .status(status)
  );

  rma_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .dcmd(dcmd), .status(status), .cmd(cmd),
    .a_whole(a_whole), .a_numer(a_numer), .a_denom(a_denom),
    .b_whole(b_whole), .b_numer(b_numer), .b_denom(b_denom),
    .res_whole(res_whole), .res_numer(res_numer), .res_denom(res_denom),
    .res_dz(div_zero)
  );
endmodule
`default_nettype wire
